// ----- design/bta_pkg.sv -----
// Package for the burst splitter: payload structs, burst geometry and the
// command descriptor shared by the front, the command queue and the back end.
// No dependencies.
package bta_pkg;

  // Burst granule; a power of two, 2**BURST_LOG2 bytes (1..1024).
  localparam int BURST_LOG2  = 6;
  localparam int BURST_BYTES = 1 << BURST_LOG2;

  localparam int ADDR_W      = 32;
  localparam int BYTE_CNT_W  = 12;
  localparam int ID_W        = 32;
  localparam int REQ_NUM_W   = 32;
  localparam int PE_W        = 8;
  localparam int PORT_W      = 4;

  // Upper bound on requests per burst; longer bursts are cut here.
  localparam int MAX_REQS    = 64;
  localparam int REQ_CNT_W   = $clog2(MAX_REQS + 1);

  // offset + length, and its round-up, fit in one more bit than the length
  // for any granule up to 1024 bytes.
  localparam int SUM_W       = BYTE_CNT_W + 1;

  // Command queue between front and back.
  localparam int CMD_DEPTH_LOG2 = 1;
  localparam int CMD_DEPTH      = 1 << CMD_DEPTH_LOG2;
  localparam int CMD_CNT_W      = CMD_DEPTH_LOG2 + 1;

  typedef enum logic {
    KIND_READ  = 1'b0,
    KIND_WRITE = 1'b1
  } kind_t;

  typedef struct packed {
    logic                  kind;
    logic [ADDR_W-1:0]     start_addr;
    logic [BYTE_CNT_W-1:0] byte_count;
    logic [ID_W-1:0]       burst_id;
    logic [PE_W-1:0]       pe_index;
    logic [PORT_W-1:0]     port_index;
  } in_item_t;

  typedef struct packed {
    logic                  req_kind;
    logic [ADDR_W-1:0]     req_addr;
    logic [ID_W-1:0]       req_burst_id;
    logic [REQ_NUM_W-1:0]  req_number;
    logic [PE_W-1:0]       req_pe;
    logic [PORT_W-1:0]     req_port;
    logic                  last_req;
  } out_item_t;

  // Classified burst: aligned base and number of requests (never zero).
  typedef struct packed {
    logic                  kind;
    logic [ADDR_W-1:0]     base_addr;
    logic [REQ_CNT_W-1:0]  req_count;
    logic [ID_W-1:0]       burst_id;
    logic [PE_W-1:0]       pe_index;
    logic [PORT_W-1:0]     port_index;
  } cmd_desc_t;

  // Status of the command queue: full for the front end, empty for the back end.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- design/bta_front.sv -----
// Front end: aligns the burst start, computes the request count and writes
// non-empty bursts into the command queue. Depends on bta_pkg.
module bta_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  bta_pkg::in_item_t   in_data,
  input  bta_pkg::q_status_t  q_status,
  output logic                q_wr_en,
  output bta_pkg::cmd_desc_t  q_wr_data
);

  logic [bta_pkg::BURST_LOG2-1:0] offset;
  logic [bta_pkg::SUM_W-1:0]      span;
  logic [bta_pkg::SUM_W-1:0]      span_up;
  logic [bta_pkg::SUM_W-1:0]      n_bursts;
  logic [bta_pkg::REQ_CNT_W-1:0]  req_count;
  logic                           accept;

  assign offset  = in_data.start_addr[bta_pkg::BURST_LOG2-1:0];
  assign span    = {1'b0, in_data.byte_count} + bta_pkg::SUM_W'(offset);
  assign span_up = span + bta_pkg::SUM_W'(bta_pkg::BURST_BYTES - 1);
  assign n_bursts = span_up >> bta_pkg::BURST_LOG2;

  // An unaligned start always spans at least one granule, so the same round-up
  // covers both cases; only an aligned empty burst yields zero.
  always_comb begin
    if (n_bursts > bta_pkg::SUM_W'(bta_pkg::MAX_REQS)) begin
      req_count = bta_pkg::REQ_CNT_W'(bta_pkg::MAX_REQS);
    end else begin
      req_count = n_bursts[bta_pkg::REQ_CNT_W-1:0];
    end
  end

  assign in_full = q_status.full;
  assign accept  = in_push && !q_status.full;
  // Drop bursts that need no request.
  assign q_wr_en = accept && (req_count != '0);

  always_comb begin
    q_wr_data.kind       = in_data.kind;
    q_wr_data.base_addr  = {in_data.start_addr[bta_pkg::ADDR_W-1:bta_pkg::BURST_LOG2],
                            {bta_pkg::BURST_LOG2{1'b0}}};
    q_wr_data.req_count  = req_count;
    q_wr_data.burst_id   = in_data.burst_id;
    q_wr_data.pe_index   = in_data.pe_index;
    q_wr_data.port_index = in_data.port_index;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr_en |-> (q_wr_data.req_count != '0) &&
                (q_wr_data.req_count <= bta_pkg::REQ_CNT_W'(bta_pkg::MAX_REQS)))
    else $error("front: descriptor count out of range");

endmodule

// ----- design/bta_cmd_fifo.sv -----
// Short command queue between front and back end; decouples their stalls.
// Depends on bta_pkg.
module bta_cmd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  bta_pkg::cmd_desc_t  wr_data,
  input  logic                rd_en,
  output bta_pkg::cmd_desc_t  rd_data,
  output bta_pkg::q_status_t  status
);

  bta_pkg::cmd_desc_t                   mem_r [bta_pkg::CMD_DEPTH];
  logic [bta_pkg::CMD_DEPTH_LOG2-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [bta_pkg::CMD_DEPTH_LOG2-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [bta_pkg::CMD_CNT_W-1:0]        cnt_r, cnt_nxt;

  assign status.full  = (cnt_r == bta_pkg::CMD_CNT_W'(bta_pkg::CMD_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign rd_data      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= bta_pkg::CMD_CNT_W'(bta_pkg::CMD_DEPTH))
    else $error("cmd_fifo: occupancy beyond depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !status.empty)
    else $error("cmd_fifo: read while empty");

endmodule

// ----- design/bta_back.sv -----
// Back end: walks one descriptor at a time, one aligned request per cycle while its
// output register is free; numbers requests, holds them there. Depends on bta_pkg.
module bta_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bta_pkg::q_status_t  q_status,
  input  bta_pkg::cmd_desc_t  q_rd_data,
  output logic                q_rd_en,
  output logic                out_empty,
  input  logic                out_pop,
  output bta_pkg::out_item_t  out_data
);

  logic                               active_r, active_nxt;
  bta_pkg::cmd_desc_t                 cur_r;
  logic [bta_pkg::REQ_CNT_W-1:0]      remain_r;
  logic [bta_pkg::REQ_NUM_W-1:0]      req_num_r;
  logic                               out_valid_r;
  bta_pkg::out_item_t                 out_data_r;

  logic out_free;
  logic emit;
  logic emit_last;

  assign out_free  = !out_valid_r || out_pop;
  assign emit      = active_r && out_free;
  assign emit_last = emit && (remain_r == bta_pkg::REQ_CNT_W'(1));
  // Fetch the next burst as soon as the current one issues its last request.
  assign q_rd_en   = (!active_r || emit_last) && !q_status.empty;

  always_comb begin
    active_nxt = active_r;
    if (emit_last) begin
      active_nxt = 1'b0;
    end
    if (q_rd_en) begin
      active_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      req_num_r   <= '0;
    end else begin
      active_r <= active_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
        req_num_r   <= req_num_r + 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd_en) begin
      cur_r    <= q_rd_data;
      remain_r <= q_rd_data.req_count;
    end else if (emit) begin
      cur_r.base_addr <= cur_r.base_addr + bta_pkg::ADDR_W'(bta_pkg::BURST_BYTES);
      remain_r        <= remain_r - 1'b1;
    end
    if (emit) begin
      out_data_r.req_kind     <= cur_r.kind;
      out_data_r.req_addr     <= cur_r.base_addr;
      out_data_r.req_burst_id <= cur_r.burst_id;
      out_data_r.req_number   <= req_num_r;
      out_data_r.req_pe       <= cur_r.pe_index;
      out_data_r.req_port     <= cur_r.port_index;
      out_data_r.last_req     <= (remain_r == bta_pkg::REQ_CNT_W'(1));
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;

  a_active_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (remain_r != '0))
    else $error("back: active with no requests left");

  a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
    emit_last |=> out_valid_r && out_data_r.last_req)
    else $error("back: final request not marked last");

  a_number_advance: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (req_num_r == $past(req_num_r) + 1'b1) &&
             (out_data_r.req_number == $past(req_num_r)))
    else $error("back: request number did not advance");

endmodule

// ----- design/burst_to_aligned_requests.sv -----
// Burst splitter top level: front end, command queue and request back end.
// Depends on bta_pkg, bta_front, bta_cmd_fifo and bta_back.
//
// Each accepted burst is cut into requests aligned to a 64-byte granule: the
// start is rounded down and ceil((offset + byte_count) / 64) requests follow,
// at most 64; an aligned burst of length zero gives none, an unaligned one of
// length zero gives one. Requests carry a 32-bit running number that starts
// at 0 after reset and wraps, and last_req marks the final one of a burst.
// The back end issues one request per cycle while its output register is free
// or being popped; the front end accepts and drops a burst with no requests.
// A two-entry command queue lets bursts be accepted while earlier ones are
// still being issued; the first request of a burst passes through a queue
// entry, the back end's descriptor register and then its output register.
module burst_to_aligned_requests (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  bta_pkg::in_item_t   in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output bta_pkg::out_item_t  out_data
);

  bta_pkg::q_status_t  q_status;
  bta_pkg::cmd_desc_t  q_wr_data;
  bta_pkg::cmd_desc_t  q_rd_data;
  logic                q_wr_en;
  logic                q_rd_en;

  bta_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .q_status  (q_status),
    .q_wr_en   (q_wr_en),
    .q_wr_data (q_wr_data)
  );

  bta_cmd_fifo u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .rd_en   (q_rd_en),
    .rd_data (q_rd_data),
    .status  (q_status)
  );

  bta_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_rd_data (q_rd_data),
    .q_rd_en   (q_rd_en),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
